// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the list manager RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define PLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define PLM_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication
`define PLM_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/plm_pkg.sv =====
// Package for the positional list manager: field widths, codes,
// controller states and the command/status structs. No dependencies.
package plm_pkg;

    // Defaults for the top-level parameters
    localparam int PLM_CAPACITY   = 256;
    localparam int PLM_VALUE_BITS = 32;

    // Fixed field widths of the channels
    localparam int OPCODE_W = 2;
    localparam int POS_W    = 9;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_HEAD  = 2'd0,
        OP_INS_AFTER = 2'd1,
        OP_DELETE    = 2'd2,
        OP_READ      = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_DONE    = 2'd0,
        RS_BAD_POS = 2'd1,
        RS_FULL    = 2'd2
    } rsp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC,
        ST_ALLOC_TAKE,
        ST_W_ISSUE,
        ST_W_STEP,
        ST_INS_HEAD,
        ST_INS_RP,
        ST_INS_W1,
        ST_INS_W2,
        ST_DEL_RP,
        ST_DEL_RQ,
        ST_DEL_RQH,
        ST_DEL_FIX,
        ST_RD_V,
        ST_RD_GET,
        ST_FINISH
    } state_t;

    // Link store read address select
    typedef enum logic [1:0] {
        LR_CUR,
        LR_DATA,
        LR_Q
    } link_rd_t;

    // Link store write operation
    typedef enum logic [2:0] {
        LW_NONE,
        LW_NEW_FROM_HEAD,
        LW_NEW_FROM_DATA,
        LW_CUR_TO_NEW,
        LW_CUR_FROM_DATA
    } link_wr_t;

    // Head pointer update
    typedef enum logic [1:0] {
        HW_KEEP,
        HW_NEW,
        HW_DATA
    } head_wr_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     setup;
        logic     alloc;
        logic     alloc_take;
        logic     step;
        link_rd_t link_rd;
        link_wr_t link_wr;
        head_wr_t head_wr;
        logic     value_we;
        logic     q_from_link;
        logic     push_q;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     rd_capture;
        logic     out_load;
    } plm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    pos_ok;
        logic    full;
        logic    pos_one;
        logic    steps_zero;
        logic    steps_last;
    } plm_sts_t;

endpackage

// ===== hw/rtl/plm_cmd_if.sv =====
// Command channel: valid/ready handshake with opcode, position and value.
// Depends on plm_pkg.
interface plm_cmd_if import plm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

// ===== hw/rtl/plm_rsp_if.sv =====
// Response channel: valid/ready handshake with status, read value and length.
// Depends on plm_pkg.
interface plm_rsp_if import plm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;

    modport source (output valid, output status, output read_value, output list_length,
                    input ready);
    modport sink   (input valid, input status, input read_value, input list_length,
                    output ready);
endinterface

// ===== hw/rtl/plm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/plm_ctrl.sv =====
// Controller FSM for the list manager: sequences decode, slot allocation,
// the link walk and the write-back. Depends on plm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module plm_ctrl import plm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  plm_sts_t sts,
    output plm_cmd_t cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // State after the walk, by opcode
    function automatic state_t post_walk(opcode_t op);
        state_t s;
        case (op)
            OP_INS_AFTER: s = ST_INS_RP;
            OP_DELETE:    s = ST_DEL_RP;
            OP_READ:      s = ST_RD_V;
            default:      s = ST_FINISH;
        endcase
        return s;
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.op != OP_INS_HEAD && !sts.pos_ok)
                begin
                    state_next = ST_FINISH;
                end
                else if ((sts.op == OP_INS_HEAD || sts.op == OP_INS_AFTER) && sts.full)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    case (sts.op)
                        OP_INS_HEAD,
                        OP_INS_AFTER: state_next = ST_ALLOC;
                        OP_DELETE:    state_next = sts.pos_one ? ST_DEL_RQH : ST_W_ISSUE;
                        OP_READ:      state_next = ST_W_ISSUE;
                        default:      state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ALLOC:      state_next = ST_ALLOC_TAKE;
            ST_ALLOC_TAKE: state_next = (sts.op == OP_INS_HEAD) ? ST_INS_HEAD : ST_W_ISSUE;
            ST_W_ISSUE:    state_next = sts.steps_zero ? post_walk(sts.op) : ST_W_STEP;
            ST_W_STEP:
            begin
                if (sts.steps_last)
                begin
                    state_next = post_walk(sts.op);
                end
            end
            ST_INS_HEAD:   state_next = ST_FINISH;
            ST_INS_RP:     state_next = ST_INS_W1;
            ST_INS_W1:     state_next = ST_INS_W2;
            ST_INS_W2:     state_next = ST_FINISH;
            ST_DEL_RP:     state_next = ST_DEL_RQ;
            ST_DEL_RQ:     state_next = ST_DEL_FIX;
            ST_DEL_RQH:    state_next = ST_DEL_FIX;
            ST_DEL_FIX:    state_next = ST_FINISH;
            ST_RD_V:       state_next = ST_RD_GET;
            ST_RD_GET:     state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.link_rd = LR_CUR;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:     cmd.setup = 1'b1;
            ST_ALLOC:      cmd.alloc = 1'b1;
            ST_ALLOC_TAKE: cmd.alloc_take = 1'b1;
            ST_W_ISSUE:    cmd.link_rd = LR_CUR;
            ST_W_STEP:
            begin
                cmd.step    = 1'b1;
                cmd.link_rd = LR_DATA;
            end
            ST_INS_HEAD:
            begin
                cmd.link_wr  = LW_NEW_FROM_HEAD;
                cmd.value_we = 1'b1;
                cmd.head_wr  = HW_NEW;
                cmd.cnt_inc  = 1'b1;
            end
            ST_INS_RP:     cmd.link_rd = LR_CUR;
            ST_INS_W1:
            begin
                cmd.link_wr  = LW_NEW_FROM_DATA;
                cmd.value_we = 1'b1;
            end
            ST_INS_W2:
            begin
                cmd.link_wr = LW_CUR_TO_NEW;
                cmd.cnt_inc = 1'b1;
            end
            ST_DEL_RP:     cmd.link_rd = LR_CUR;
            ST_DEL_RQ:
            begin
                cmd.q_from_link = 1'b1;
                cmd.link_rd     = LR_DATA;
            end
            ST_DEL_RQH:    cmd.link_rd = LR_Q;
            ST_DEL_FIX:
            begin
                if (sts.pos_one)
                begin
                    cmd.head_wr = HW_DATA;
                end
                else
                begin
                    cmd.link_wr = LW_CUR_FROM_DATA;
                end
                cmd.push_q  = 1'b1;
                cmd.cnt_dec = 1'b1;
            end
            ST_RD_V:       cmd.link_rd = LR_CUR;
            ST_RD_GET:     cmd.rd_capture = 1'b1;
            ST_FINISH:     cmd.out_load = out_free;
            default:       cmd.link_rd = LR_CUR;
        endcase
    end

    // Response valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PLM_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_reg == ST_DECODE, "accepted item did not start decode")
    `PLM_ASSERT_IMP(a_alloc_not_full, state_reg == ST_ALLOC, !sts.full, "allocation on a full list")
    `PLM_ASSERT_IMP(a_walk_steps, state_reg == ST_W_STEP, !sts.steps_zero, "walk ran past its step count")
endmodule

// ===== hw/rtl/plm_dp.sv =====
// Datapath of the list manager: value, link and free-slot stores, head,
// count, walk pointer and response registers. Depends on plm_pkg, plm_ram.
`include "assert_macros.svh"
module plm_dp import plm_pkg::*; #(
    parameter int CAPACITY   = PLM_CAPACITY,
    parameter int VALUE_BITS = PLM_VALUE_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  plm_cmd_t                 cmd,
    output plm_sts_t                 sts,
    input  logic [OPCODE_W-1:0]      in_opcode,
    input  logic [POS_W-1:0]         in_position,
    input  logic signed [DATA_W-1:0] in_item_value,
    output logic [STATUS_W-1:0]      out_status,
    output logic signed [DATA_W-1:0] out_read_value,
    output logic [LEN_W-1:0]         out_list_length
);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0]  CAP_C   = CNT_W'(CAPACITY);
    localparam logic [LINK_W-1:0] NULL_L  = LINK_W'(CAPACITY);

    // Command registers
    opcode_t                 op_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    // List control state
    logic [LINK_W-1:0]       head_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        fresh_reg;
    logic [CNT_W-1:0]        rtop_reg;
    // Walk and work registers
    logic [LINK_W-1:0]       cur_reg;
    logic [CNT_W-1:0]        steps_reg;
    logic [SLOT_W-1:0]       ns_reg;
    logic [LINK_W-1:0]       q_reg;
    logic                    from_stack_reg;
    rsp_status_t             status_reg;
    logic [DATA_W-1:0]       rd_reg;
    // Response registers
    logic [STATUS_W-1:0]     out_status_reg;
    logic [DATA_W-1:0]       out_read_reg;
    logic [LEN_W-1:0]        out_len_reg;

    // Store ports
    logic                    link_we;
    logic [SLOT_W-1:0]       link_waddr, link_raddr;
    logic [LINK_W-1:0]       link_wdata, link_rdata;
    logic [VALUE_BITS-1:0]   value_rdata;
    logic [SLOT_W-1:0]       free_rdata;
    logic [CNT_W-1:0]        rtop_dec;

    // Decode helpers
    logic [CMP_W-1:0]        pos_x, cnt_x, walk_n;
    logic                    pos_ok, full, is_insert;
    rsp_status_t             status_next;
    logic signed [63:0]      in_ext, rd_ext;
    logic signed [VALUE_BITS-1:0] value_s;
    logic [CNT_W:0]          used_x;

    assign pos_x     = CMP_W'(pos_reg);
    assign cnt_x     = CMP_W'(count_reg);
    assign pos_ok    = (pos_x != '0) && (pos_x <= cnt_x);
    assign full      = (count_reg == CAP_C);
    assign is_insert = (op_reg == OP_INS_HEAD) || (op_reg == OP_INS_AFTER);
    // Links to follow: to the target for insert/read, to its predecessor for delete
    assign walk_n    = (op_reg == OP_DELETE) ? (pos_x - CMP_W'(2)) : (pos_x - CMP_W'(1));
    assign rtop_dec  = rtop_reg - CNT_W'(1);
    // Recycled plus live slots; a slot taken for an insert joins the count later, when the insert writes its links
    assign used_x    = (CNT_W + 1)'(rtop_reg) + (CNT_W + 1)'(count_reg);

    always_comb
    begin
        status_next = RS_DONE;
        if (op_reg != OP_INS_HEAD && !pos_ok)
        begin
            status_next = RS_BAD_POS;
        end
        else if (is_insert && full)
        begin
            status_next = RS_FULL;
        end
    end

    assign sts.op         = op_reg;
    assign sts.pos_ok     = pos_ok;
    assign sts.full       = full;
    assign sts.pos_one    = (pos_reg == POS_W'(1));
    assign sts.steps_zero = (steps_reg == '0);
    assign sts.steps_last = (steps_reg == CNT_W'(1));

    // Value sign handling on store and read-back
    assign in_ext  = 64'(in_item_value);
    assign value_s = value_rdata;
    assign rd_ext  = 64'(value_s);

    // Link store address and data selection
    always_comb
    begin
        case (cmd.link_rd)
            LR_CUR:  link_raddr = cur_reg[SLOT_W-1:0];
            LR_DATA: link_raddr = link_rdata[SLOT_W-1:0];
            LR_Q:    link_raddr = q_reg[SLOT_W-1:0];
            default: link_raddr = cur_reg[SLOT_W-1:0];
        endcase
    end

    always_comb
    begin
        link_we    = 1'b1;
        link_waddr = ns_reg;
        link_wdata = head_reg;
        case (cmd.link_wr)
            LW_NEW_FROM_HEAD: link_wdata = head_reg;
            LW_NEW_FROM_DATA: link_wdata = link_rdata;
            LW_CUR_TO_NEW:
            begin
                link_waddr = cur_reg[SLOT_W-1:0];
                link_wdata = LINK_W'(ns_reg);
            end
            LW_CUR_FROM_DATA:
            begin
                link_waddr = cur_reg[SLOT_W-1:0];
                link_wdata = link_rdata;
            end
            default:          link_we = 1'b0;
        endcase
    end

    plm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_values (
        .clk   (clk),
        .we    (cmd.value_we),
        .waddr (ns_reg),
        .wdata (val_reg),
        .raddr (cur_reg[SLOT_W-1:0]),
        .rdata (value_rdata)
    );

    plm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Stack of recycled slots; never-used slots come from fresh_reg
    plm_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
        .clk   (clk),
        .we    (cmd.push_q),
        .waddr (rtop_reg[SLOT_W-1:0]),
        .wdata (q_reg[SLOT_W-1:0]),
        .raddr (rtop_dec[SLOT_W-1:0]),
        .rdata (free_rdata)
    );

    // List control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NULL_L;
            count_reg <= '0;
            fresh_reg <= '0;
            rtop_reg  <= '0;
        end
        else
        begin
            case (cmd.head_wr)
                HW_NEW:  head_reg <= LINK_W'(ns_reg);
                HW_DATA: head_reg <= link_rdata;
                default: head_reg <= head_reg;
            endcase
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.alloc)
            begin
                if (rtop_reg != '0)
                begin
                    rtop_reg <= rtop_dec;
                end
                else
                begin
                    fresh_reg <= fresh_reg + CNT_W'(1);
                end
            end
            else if (cmd.push_q)
            begin
                rtop_reg <= rtop_reg + CNT_W'(1);
            end
        end
    end

    // Command latch, walk and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(in_opcode);
            pos_reg <= in_position;
            val_reg <= in_ext[VALUE_BITS-1:0];
        end
        if (cmd.setup)
        begin
            status_reg <= status_next;
            rd_reg     <= '0;
            cur_reg    <= head_reg;
            q_reg      <= head_reg;
            steps_reg  <= walk_n[CNT_W-1:0];
        end
        if (cmd.step)
        begin
            cur_reg   <= link_rdata;
            steps_reg <= steps_reg - CNT_W'(1);
        end
        if (cmd.q_from_link)
        begin
            q_reg <= link_rdata;
        end
        if (cmd.alloc)
        begin
            from_stack_reg <= (rtop_reg != '0);
            ns_reg         <= fresh_reg[SLOT_W-1:0];
        end
        if (cmd.alloc_take && from_stack_reg)
        begin
            ns_reg <= free_rdata;
        end
        if (cmd.rd_capture)
        begin
            rd_reg <= rd_ext[DATA_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_read_reg   <= rd_reg;
            out_len_reg    <= cnt_x[LEN_W-1:0];
        end
    end

    assign out_status      = out_status_reg;
    assign out_read_value  = out_read_reg;
    assign out_list_length = out_len_reg;

    `PLM_ASSERT(a_count_range, count_reg <= CAP_C, "entry count above capacity")
    `PLM_ASSERT(a_free_balance, used_x <= (CNT_W + 1)'(fresh_reg), "free slot accounting broken")
    `PLM_ASSERT_IMP(a_push_room, cmd.push_q, rtop_reg < CAP_C, "free stack overflow")
    `PLM_ASSERT_IMP(a_fresh_room, cmd.alloc && rtop_reg == '0, fresh_reg < CAP_C, "no fresh slot left")
endmodule

// ===== hw/rtl/positional_list_manager_top.sv =====
// Top level of the positional list manager: controller plus datapath.
// Depends on plm_pkg, plm_cmd_if, plm_rsp_if, plm_ctrl, plm_dp, plm_ram.
//
// Usage: commands arrive on the cmd channel (opcode, position, item_value)
// and each produces exactly one item on the rsp channel (status,
// read_value, list_length), valid/ready on both. Opcodes: insert at head,
// insert after a 1-based position, delete at a position, read at a position.
// One command is worked at a time; cmd.ready is high only while idle.
// The walk through the link store, one link per cycle over its registered
// read port, makes the run time of insert after, read and delete grow with
// the position; an invalid or full command skips it. The next command is
// taken in the cycle after the response is loaded.
// The response register frees the controller: a new command is accepted
// while the previous response still waits. If rsp.ready stays low, the
// next command finishes and then waits until the held response is taken.
// Reset (asynchronous, active low) empties the list and the free pool;
// no clearing pass is needed, so commands are taken right after reset.
module positional_list_manager_top import plm_pkg::*; #(
    parameter int CAPACITY   = PLM_CAPACITY,
    parameter int VALUE_BITS = PLM_VALUE_BITS
) (
    input  logic  clk,
    input  logic  rst_n,
    plm_cmd_if.sink   cmd,
    plm_rsp_if.source rsp
);
    plm_cmd_t ctl_cmd;
    plm_sts_t dp_sts;

    plm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (dp_sts),
        .cmd       (ctl_cmd)
    );

    plm_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctl_cmd),
        .sts             (dp_sts),
        .in_opcode       (cmd.opcode),
        .in_position     (cmd.position),
        .in_item_value   (cmd.item_value),
        .out_status      (rsp.status),
        .out_read_value  (rsp.read_value),
        .out_list_length (rsp.list_length)
    );
endmodule
